// ----- rtl/char_lcd_shadow_refresh_macros.svh -----
// Assertion macros shared by the character display checker.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef CHAR_LCD_SHADOW_REFRESH_MACROS_SVH
`define CHAR_LCD_SHADOW_REFRESH_MACROS_SVH

// Property checked on every rising edge, ignored while reset is held.
`define CLSR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every rising edge, reset included.
`define CLSR_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/clsr_pkg.sv -----
// Shared constants and helpers for the shadow-buffered character display controller.
// No dependencies; used by the top level and its checker.
package clsr_pkg;

  // Default number of display cells (two rows).
  localparam int CELL_COUNT_DEF = 32;

  // Field widths of the request and result items.
  localparam int OP_W   = 2;
  localparam int CHAR_W = 8;
  localparam int POS_W  = 5;
  localparam int BYTE_W = 8;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_SET   = 2'd0;
  localparam logic [OP_W-1:0] OP_FLUSH = 2'd1;
  localparam logic [OP_W-1:0] OP_INIT  = 2'd2;

  // Display command constants.
  localparam logic [BYTE_W-1:0] ROW_TWO_BASE = 8'h40;
  localparam logic [BYTE_W-1:0] SET_ADDR_CMD = 8'h80;

  // Wake-up sequence length and counter width.
  localparam int WAKE_LEN = 9;
  localparam int WAKE_W   = $clog2(WAKE_LEN);

  // Byte k of the fixed wake-up command sequence.
  function automatic logic [BYTE_W-1:0] wake_byte(input logic [WAKE_W-1:0] k);
    logic [BYTE_W-1:0] b;
    case (k)
      4'd0:    b = 8'h30;
      4'd1:    b = 8'h30;
      4'd2:    b = 8'h30;
      4'd3:    b = 8'h38;
      4'd4:    b = 8'h10;
      4'd5:    b = 8'h0C;
      4'd6:    b = 8'h06;
      4'd7:    b = SET_ADDR_CMD | 8'h00;
      4'd8:    b = 8'h01;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// ----- rtl/char_lcd_shadow_refresh.sv -----
// Shadow-buffered character display controller: shadow memory, dirty marks, bus sequencer.
// Depends on clsr_pkg.
//
//  channel | dir | tdata (low bit up)                      | tuser    | tlast
//  --------+-----+-----------------------------------------+----------+------------
//  in_     | in  | op[1:0], char_code[9:2], position[14:10] | -        | -
//  out_    | out | bus_byte[7:0]                            | is_data  | last write
//
// A set request steps through accept, read, then compare and write.
// A flush scans the cells in order and, for each dirty cell, issues an address
// command and a data write, stopping after the last dirty cell; an init issues
// the wake-up commands in order. All of these steps follow the accept.
// The single shadow-memory read port and the output register pace these steps.
// Output stalls hold the sequencer; reset clears dirty marks and cell valid bits.
module char_lcd_shadow_refresh
  import clsr_pkg::*;
#(
  parameter int CELL_COUNT = CELL_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // op[1:0], char_code[9:2], position[14:10], zero fill
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // bus_byte[7:0]
  output logic [0:0]  out_tuser,  // is_data[0]
  output logic        out_tlast
);

  localparam int IDX_W = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
  localparam int HALF  = CELL_COUNT / 2;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_SET_RD = 7'b0000010,
    ST_SET_WR = 7'b0000100,
    ST_SCAN   = 7'b0001000,
    ST_ADDR   = 7'b0010000,
    ST_DATA   = 7'b0100000,
    ST_INIT   = 7'b1000000
  } state_t;

  // Request fields.
  logic [OP_W-1:0]   in_op;
  logic [CHAR_W-1:0] in_char_code;
  logic [POS_W-1:0]  in_position;
  assign in_op        = in_tdata[1:0];
  assign in_char_code = in_tdata[9:2];
  assign in_position  = in_tdata[14:10];

  state_t                state_r, state_nxt;
  logic [IDX_W-1:0]      idx_r, idx_nxt;
  logic [CHAR_W-1:0]     code_r, code_nxt;
  logic                  pos_ok_r, pos_ok_nxt;
  logic [WAKE_W-1:0]     wake_r, wake_nxt;
  logic [CELL_COUNT-1:0] dirty_r, dirty_nxt;
  logic [CELL_COUNT-1:0] cvalid_r, cvalid_nxt;

  // Shadow memory with one registered read port at idx_r.
  logic [CHAR_W-1:0] mem [CELL_COUNT];
  logic [CHAR_W-1:0] rd_data_r;
  logic              rd_vld_r;
  logic [CHAR_W-1:0] cell_char;
  logic              mem_we;

  // Output register.
  logic              out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0] out_byte_r, out_byte_nxt;
  logic              out_isd_r, out_isd_nxt;
  logic              out_last_r, out_last_nxt;
  logic              slot_free;

  logic              in_acc;
  logic              more_above;
  logic              idx_end;
  logic [CELL_COUNT:0] low_mask;
  logic [IDX_W:0]      idx_inc;
  logic [BYTE_W-1:0]   disp_addr;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign slot_free  = !out_valid_r || out_tready;
  assign cell_char  = rd_vld_r ? rd_data_r : '0;

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_byte_r;
  assign out_tuser[0] = out_isd_r;
  assign out_tlast    = out_last_r;

  // Any dirty cell above the current scan index.
  assign idx_inc    = {1'b0, idx_r} + 1'b1;
  assign low_mask   = ({{CELL_COUNT{1'b0}}, 1'b1} << idx_inc) - 1'b1;
  assign more_above = |(dirty_r & ~low_mask[CELL_COUNT-1:0]);
  assign idx_end    = ({1'b0, idx_r} == (IDX_W+1)'(CELL_COUNT - 1));

  // Display address of the current cell; row two starts at 0x40.
  always_comb begin
    if ({1'b0, idx_r} < (IDX_W+1)'(HALF)) begin
      disp_addr = BYTE_W'(idx_r);
    end else begin
      disp_addr = ROW_TWO_BASE + BYTE_W'(idx_r) - BYTE_W'(HALF);
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    code_nxt      = code_r;
    pos_ok_nxt    = pos_ok_r;
    wake_nxt      = wake_r;
    dirty_nxt     = dirty_r;
    cvalid_nxt    = cvalid_r;
    mem_we        = 1'b0;
    out_valid_nxt = out_valid_r && !out_tready;
    out_byte_nxt  = out_byte_r;
    out_isd_nxt   = out_isd_r;
    out_last_nxt  = out_last_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_op)
            OP_SET: begin
              pos_ok_nxt = ({1'b0, in_position} < (POS_W+1)'(CELL_COUNT));
              idx_nxt    = in_position[IDX_W-1:0];
              code_nxt   = in_char_code;
              state_nxt  = ST_SET_RD;
            end
            OP_FLUSH: begin
              idx_nxt   = '0;
              state_nxt = ST_SCAN;
            end
            OP_INIT: begin
              wake_nxt  = '0;
              state_nxt = ST_INIT;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_SET_RD: begin
        state_nxt = ST_SET_WR;
      end
      ST_SET_WR: begin
        // Store and mark only when the position is in range and the code changes.
        if (pos_ok_r && (cell_char != code_r)) begin
          mem_we            = 1'b1;
          cvalid_nxt[idx_r] = 1'b1;
          dirty_nxt[idx_r]  = 1'b1;
        end
        state_nxt = ST_IDLE;
      end
      ST_SCAN: begin
        if (dirty_r[idx_r]) begin
          state_nxt = ST_ADDR;
        end else if (!more_above || idx_end) begin
          state_nxt = ST_IDLE;
        end else begin
          idx_nxt = idx_inc[IDX_W-1:0];
        end
      end
      ST_ADDR: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = SET_ADDR_CMD | disp_addr;
          out_isd_nxt   = 1'b0;
          out_last_nxt  = 1'b0;
          state_nxt     = ST_DATA;
        end
      end
      ST_DATA: begin
        if (slot_free) begin
          out_valid_nxt    = 1'b1;
          out_byte_nxt     = cell_char;
          out_isd_nxt      = 1'b1;
          out_last_nxt     = !more_above;
          dirty_nxt[idx_r] = 1'b0;
          if (!more_above || idx_end) begin
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt   = idx_inc[IDX_W-1:0];
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_INIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = wake_byte(wake_r);
          out_isd_nxt   = 1'b0;
          out_last_nxt  = (wake_r == WAKE_W'(WAKE_LEN - 1));
          if (wake_r == WAKE_W'(WAKE_LEN - 1)) begin
            state_nxt = ST_IDLE;
          end else begin
            wake_nxt = wake_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      dirty_r     <= '0;
      cvalid_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      dirty_r     <= dirty_nxt;
      cvalid_r    <= cvalid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    code_r     <= code_nxt;
    pos_ok_r   <= pos_ok_nxt;
    wake_r     <= wake_nxt;
    out_byte_r <= out_byte_nxt;
    out_isd_r  <= out_isd_nxt;
    out_last_r <= out_last_nxt;
  end

  // Shadow memory write and registered read; unwritten cells read as zero.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[idx_r] <= code_r;
    end
    rd_data_r <= mem[idx_r];
    rd_vld_r  <= cvalid_nxt[idx_r];
  end

endmodule

// ----- rtl/char_lcd_shadow_refresh_chk.sv -----
// Port-level checker for the shadow-buffered character display controller.
// Depends on clsr_pkg and char_lcd_shadow_refresh_macros.svh; bound to the top level.
`include "char_lcd_shadow_refresh_macros.svh"

module char_lcd_shadow_refresh_chk
  import clsr_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [15:0] in_tdata,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [7:0]  out_tdata,
  input logic [0:0]  out_tuser,
  input logic        out_tlast
);

  // A stalled result holds its payload.
  `CLSR_ASSERT(a_out_hold,
               out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
                 && $stable(out_tuser) && $stable(out_tlast),
               "stalled result changed")

  // Any request other than the unused code keeps the block busy next cycle.
  `CLSR_ASSERT(a_busy_after_req,
               in_tvalid && in_tready && (in_tdata[OP_W-1:0] == OP_SET
                 || in_tdata[OP_W-1:0] == OP_FLUSH || in_tdata[OP_W-1:0] == OP_INIT)
                 |=> !in_tready,
               "block ready right after a request")

  // Once idle again, only the final write of the previous request can still wait.
  `CLSR_ASSERT(a_idle_pending_last, in_tready && out_tvalid |-> out_tlast,
               "non-final write pending while idle")

  // Reset empties the output register.
  `CLSR_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_tvalid, "result valid after reset")

endmodule

bind char_lcd_shadow_refresh char_lcd_shadow_refresh_chk u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

// ----- verif/char_lcd_shadow_refresh_test.sv -----
// Self-checking testbench for the shadow-buffered character display controller.
// Depends on clsr_pkg and char_lcd_shadow_refresh; a directed table, then random requests.
`timescale 1ns / 1ps

module char_lcd_shadow_refresh_test
  import clsr_pkg::*;
();

  localparam int CELLS = CELL_COUNT_DEF;
  localparam int ROW_CELLS = CELLS / 2;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  // One bus write as seen on the result channel.
  typedef struct packed {
    logic              is_data;
    logic [BYTE_W-1:0] bus_byte;
    logic              last;
  } bus_write_t;

  // One row of the directed table. Where fixed is set, the listed writes
  // ({is_data, byte}, first write leftmost) are expected instead of the prediction.
  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [CHAR_W-1:0] char_code;
    logic [POS_W-1:0]  position;
    logic              fixed;
    logic [3:0]        n_fixed;
    logic [0:8][8:0]   fixed_writes;
  } stim_row_t;

  localparam logic [0:8][8:0] NO_WRITES = '0;
  localparam logic [0:8][8:0] WAKE_WRITES = {
    9'h030, 9'h030, 9'h030, 9'h038, 9'h010, 9'h00C, 9'h006, 9'h080, 9'h001
  };
  // Cells 0, 15, 16 and 31 written with 0xFF, 0x01, 0x7F and 0x80.
  localparam logic [0:8][8:0] CORNER_WRITES = {
    9'h080, 9'h1FF, 9'h08F, 9'h101, 9'h0C0, 9'h17F, 9'h0CF, 9'h180, 9'h000
  };
  localparam logic [7:0] WAKE_SEQ [WAKE_LEN] = '{
    8'h30, 8'h30, 8'h30, 8'h38, 8'h10, 8'h0C, 8'h06, 8'h80, 8'h01
  };

  localparam int DIRECTED_N = 21;
  localparam stim_row_t DIRECTED_ROWS [DIRECTED_N] = '{
    '{OP_FLUSH,  8'h00, 5'd0,  1'b1, 4'd0, NO_WRITES},      // nothing dirty after reset
    '{OP_INIT,   8'h00, 5'd0,  1'b1, 4'd9, WAKE_WRITES},
    '{OP_SET,    8'h00, 5'd0,  1'b1, 4'd0, NO_WRITES},      // same code, stays clean
    '{OP_FLUSH,  8'h00, 5'd0,  1'b1, 4'd0, NO_WRITES},
    '{OP_SET,    8'hFF, 5'd0,  1'b0, 4'd0, NO_WRITES},
    '{OP_SET,    8'h01, 5'd15, 1'b0, 4'd0, NO_WRITES},
    '{OP_SET,    8'h7F, 5'd16, 1'b0, 4'd0, NO_WRITES},
    '{OP_SET,    8'h80, 5'd31, 1'b0, 4'd0, NO_WRITES},
    '{OP_FLUSH,  8'h00, 5'd0,  1'b1, 4'd8, CORNER_WRITES},
    '{OP_FLUSH,  8'h00, 5'd0,  1'b1, 4'd0, NO_WRITES},      // marks were cleared
    '{OP_UNUSED, 8'hFF, 5'd31, 1'b1, 4'd0, NO_WRITES},
    '{OP_SET,    8'h41, 5'd5,  1'b0, 4'd0, NO_WRITES},
    '{OP_SET,    8'h41, 5'd5,  1'b0, 4'd0, NO_WRITES},
    '{OP_SET,    8'h12, 5'd7,  1'b0, 4'd0, NO_WRITES},
    '{OP_SET,    8'h00, 5'd7,  1'b0, 4'd0, NO_WRITES},      // back to zero, still dirty
    '{OP_FLUSH,  8'h00, 5'd0,  1'b0, 4'd0, NO_WRITES},
    '{OP_SET,    8'h55, 5'd20, 1'b0, 4'd0, NO_WRITES},
    '{OP_INIT,   8'hA5, 5'd9,  1'b1, 4'd9, WAKE_WRITES},    // leaves the dirty mark alone
    '{OP_FLUSH,  8'h00, 5'd0,  1'b0, 4'd0, NO_WRITES},
    '{OP_UNUSED, 8'h00, 5'd0,  1'b1, 4'd0, NO_WRITES},
    '{OP_FLUSH,  8'h00, 5'd0,  1'b1, 4'd0, NO_WRITES}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;    // op[1:0], char_code[9:2], position[14:10], zero fill
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;        // bus_byte[7:0]
  logic [0:0]  out_tuser;        // is_data[0]
  logic        out_tlast;

  // Predictor copy of the shadow memory and dirty marks.
  logic [CHAR_W-1:0] shadow_chars [CELLS];
  logic              shadow_dirty [CELLS];
  bus_write_t        predicted_writes [$];
  bus_write_t        expected_writes [$];
  int                fail_count = 0;
  bit                steady = 1'b0;

  char_lcd_shadow_refresh dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Work out the bus writes that one request causes and update the shadow state.
  function automatic void predict_bus_writes(input logic [OP_W-1:0] op,
                                             input logic [CHAR_W-1:0] code,
                                             input logic [POS_W-1:0] pos);
    logic [BYTE_W-1:0] addr;
    predicted_writes.delete();
    case (op)
      OP_SET: begin
        if (int'(pos) < CELLS && shadow_chars[pos] != code) begin
          shadow_chars[pos] = code;
          shadow_dirty[pos] = 1'b1;
        end
      end
      OP_FLUSH: begin
        for (int i = 0; i < CELLS; i++) begin
          if (shadow_dirty[i]) begin
            addr = (i < ROW_CELLS) ? BYTE_W'(i) : ROW_TWO_BASE + BYTE_W'(i - ROW_CELLS);
            predicted_writes.push_back('{1'b0, SET_ADDR_CMD | addr, 1'b0});
            predicted_writes.push_back('{1'b1, shadow_chars[i], 1'b0});
            shadow_dirty[i] = 1'b0;
          end
        end
      end
      OP_INIT: begin
        for (int k = 0; k < WAKE_LEN; k++)
          predicted_writes.push_back('{1'b0, WAKE_SEQ[k], 1'b0});
      end
      default: ;
    endcase
    if (predicted_writes.size() > 0) predicted_writes[predicted_writes.size() - 1].last = 1'b1;
  endfunction

  // Present one request, wait for it to be taken, then queue what it should cause.
  task automatic send_request(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] code,
                              input logic [POS_W-1:0] pos, input logic fixed,
                              input logic [3:0] n_fixed, input logic [0:8][8:0] fixed_writes);
    while (!steady && $urandom_range(99) < 12) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, pos, code, op};
    do @(posedge clk); while (!in_tready);
    predict_bus_writes(op, code, pos);
    if (fixed) begin
      for (int j = 0; j < int'(n_fixed); j++)
        expected_writes.push_back('{fixed_writes[j][8], fixed_writes[j][7:0],
                                    j == int'(n_fixed) - 1});
    end else begin
      foreach (predicted_writes[j]) expected_writes.push_back(predicted_writes[j]);
    end
  endtask

  // Dirty every cell with a changed code, then flush all of them at once.
  task automatic fill_and_flush();
    for (int i = 0; i < CELLS; i++)
      send_request(OP_SET, ~shadow_chars[i], POS_W'(i), 1'b0, 4'd0, NO_WRITES);
    send_request(OP_FLUSH, CHAR_W'($urandom_range(255)), POS_W'($urandom_range(31)),
                 1'b0, 4'd0, NO_WRITES);
  endtask

  // Result side back-pressure.
  always @(posedge clk) begin
    out_tready <= steady || ($urandom_range(99) >= 12);
  end

  // Compare each accepted bus write with the oldest expectation.
  always @(posedge clk) begin
    bus_write_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_writes.size() == 0) begin
        $error("unexpected bus write: is_data %0d, bus_byte 0x%02h, last %0d",
               out_tuser[0], out_tdata, out_tlast);
        fail_count++;
      end else begin
        want = expected_writes.pop_front();
        if (out_tuser[0] !== want.is_data) begin
          $error("is_data: expected %0d, got %0d", want.is_data, out_tuser[0]);
          fail_count++;
        end
        if (out_tdata !== want.bus_byte) begin
          $error("bus_byte: expected 0x%02h, got 0x%02h", want.bus_byte, out_tdata);
          fail_count++;
        end
        if (out_tlast !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, out_tlast);
          fail_count++;
        end
      end
    end
  end

  // Stimulus: directed table, then random requests.
  initial begin
    int r;
    logic [POS_W-1:0]  pos;
    logic [CHAR_W-1:0] code;
    for (int i = 0; i < CELLS; i++) begin
      shadow_chars[i] = '0;
      shadow_dirty[i] = 1'b0;
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int n = 0; n < DIRECTED_N; n++)
      send_request(DIRECTED_ROWS[n].op, DIRECTED_ROWS[n].char_code, DIRECTED_ROWS[n].position,
                   DIRECTED_ROWS[n].fixed, DIRECTED_ROWS[n].n_fixed,
                   DIRECTED_ROWS[n].fixed_writes);

    // Mostly character updates with random flushes, inits and unused codes; some
    // updates repeat the stored code so that they must not mark the cell.
    for (int k = 0; k < 160; k++) begin
      steady = (k >= 90 && k < 130);
      if (k == 30 || k == 110) fill_and_flush();
      r    = $urandom_range(99);
      pos  = POS_W'($urandom_range(31));
      code = CHAR_W'($urandom_range(255));
      if (r < 70) begin
        if ($urandom_range(99) < 30) code = shadow_chars[pos];
        send_request(OP_SET, code, pos, 1'b0, 4'd0, NO_WRITES);
      end else if (r < 88)
        send_request(OP_FLUSH, code, pos, 1'b0, 4'd0, NO_WRITES);
      else if (r < 95)
        send_request(OP_INIT, code, pos, 1'b0, 4'd0, NO_WRITES);
      else
        send_request(OP_UNUSED, code, pos, 1'b0, 4'd0, NO_WRITES);
    end
    steady = 1'b0;
    in_tvalid <= 1'b0;

    // Drain, then leave room for any stray write of a long flush.
    while (expected_writes.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #4_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
